FILE: rtl/pkt_pkg.sv
package pkt_pkg;

   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int AGE_W  = 8;
   localparam int CFG_W  = 7;
   localparam int CNT_W  = 3;
   localparam int ACT_W  = 2;

   localparam logic [AGE_W-1:0] AGE_MAX       = 8'd255;
   localparam logic [CFG_W-1:0] AGE_LIMIT_RST = 7'd10;
   localparam logic [CFG_W-1:0] AGE_STEP_RST  = 7'd5;

   // request action codes
   localparam logic [ACT_W-1:0] ACT_ALIVE      = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DISCONNECT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK       = 2'd2;

   // csr register indexes
   localparam logic CSR_AGE_LIMIT = 1'b0;
   localparam logic CSR_AGE_STEP  = 1'b1;

   // result kinds
   localparam logic EV_ALIVE = 1'b0;
   localparam logic EV_DEAD  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COMMIT,
      ST_FLUSH
   } state_type;

   typedef enum logic {
      OP_KEY,
      OP_AGE
   } alu_op_type;

   typedef struct packed {
      logic             flag;
      logic [AGE_W-1:0] age_next;
   } alu_res_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic [AGE_W-1:0]  age;
   } slot_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic [CNT_W-1:0]  count;
   } event_type;

endpackage

FILE: rtl/pkt_req_if.sv
interface pkt_req_if;
   import pkt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [ADDR_W-1:0] peer_address;
   logic [PORT_W-1:0] peer_port;

   modport source (output valid, output action, output peer_address, output peer_port,
                   input ready);
   modport sink   (input valid, input action, input peer_address, input peer_port,
                   output ready);
endinterface

FILE: rtl/pkt_rsp_if.sv
interface pkt_rsp_if;
   import pkt_pkg::*;

   logic              valid;
   logic              ready;
   logic              event_kind;
   logic [ADDR_W-1:0] event_address;
   logic [PORT_W-1:0] event_port;
   logic [CNT_W-1:0]  peer_count;
   logic              last;

   modport source (output valid, output event_kind, output event_address,
                   output event_port, output peer_count, output last, input ready);
   modport sink   (input valid, input event_kind, input event_address,
                   input event_port, input peer_count, input last, output ready);
endinterface

FILE: rtl/pkt_slot_mem.sv
module pkt_slot_mem #(
   parameter int DEPTH = 4,
   parameter int IW    = 2
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [IW-1:0]             rd_idx,
   output pkt_pkg::slot_type         rd_data,
   input  logic                      key_we,
   input  logic                      age_we,
   input  logic [IW-1:0]             wr_idx,
   input  logic [pkt_pkg::ADDR_W-1:0] wr_address,
   input  logic [pkt_pkg::PORT_W-1:0] wr_port,
   input  logic [pkt_pkg::AGE_W-1:0]  wr_age
);
   import pkt_pkg::*;

   logic [ADDR_W-1:0] address_mem [DEPTH];
   logic [PORT_W-1:0] port_mem    [DEPTH];
   logic [AGE_W-1:0]  age_mem     [DEPTH];
   slot_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         address_mem[wr_idx] <= wr_address;
         port_mem[wr_idx]    <= wr_port;
      end
      if (age_we) begin
         age_mem[wr_idx] <= wr_age;
      end
      if (rd_en) begin
         rd_data_ff <= '{address: address_mem[rd_idx], port: port_mem[rd_idx],
                         age: age_mem[rd_idx]};
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pkt_alu.sv
module pkt_alu (
   input  pkt_pkg::alu_op_type          op,
   input  logic [pkt_pkg::ADDR_W-1:0]   key_a,
   input  logic [pkt_pkg::ADDR_W-1:0]   key_b,
   input  logic [pkt_pkg::AGE_W-1:0]    age,
   input  logic [pkt_pkg::CFG_W-1:0]    limit,
   input  logic [pkt_pkg::CFG_W-1:0]    step,
   output pkt_pkg::alu_res_type         res
);
   import pkt_pkg::*;

   logic [AGE_W:0] sum;

   always_comb begin
      sum = {1'b0, age} + {{(AGE_W + 1 - CFG_W){1'b0}}, step};
      res.age_next = sum[AGE_W] ? AGE_MAX : sum[AGE_W-1:0];
      case (op)
         OP_KEY:  res.flag = (key_a == key_b);
         // flag set: entry is past the limit and gets dropped
         OP_AGE:  res.flag = (age > {{(AGE_W - CFG_W){1'b0}}, limit});
         default: res.flag = 1'b0;
      endcase
   end

endmodule

FILE: rtl/peer_keepalive_table_unit.sv
// Peer keepalive table: up to MAX_PEERS peers keyed by IPv4 address. An alive
// check refreshes (or adds, into the lowest free slot) the sender and returns
// one alive response; a disconnect drops the sender if present and returns one
// dead notice; an aging tick ages every held peer by age_step (saturating at
// 255) and drops, with a dead notice each, those already past age_limit, in slot
// order. The last result of a request has last set; a tick that drops nothing
// returns no result, as does the unused action code. Timing: one request at a
// time. Each request scans every slot; an alive check or disconnect then builds
// its response in a commit state, and a flush state moves the last result from
// the held-result register into the output register, waiting on rsp.ready while
// the output register is still full (a tick's scan holds the same way before a
// second drop). The next request can be taken in the cycle after that load, so
// it waits for the whole scan; the unused code leaves the block idle. The scan
// walks the slots in turn: the slot store has one registered read port and one
// shared compare/add unit, so each slot passes through a read state and an
// evaluate state. One result may sit in the output register while the next
// request is accepted. Config writes are taken whenever csr_we is high and
// belong only to idle periods.
module peer_keepalive_table_unit #(
   parameter int MAX_PEERS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   pkt_req_if.sink                      req,
   pkt_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [pkt_pkg::CFG_W-1:0]    csr_data
);
   import pkt_pkg::*;

   localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW = $clog2(MAX_PEERS + 1);

   // ---------------------------------------------------------------- state
   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  age_limit_ff, age_step_ff;
   logic [MAX_PEERS-1:0] valid_ff;
   logic [CW-1:0]     count_ff;
   logic [IW-1:0]     idx_ff;
   logic              hit_ff, free_ff;
   logic [IW-1:0]     hit_idx_ff, free_idx_ff;
   logic [ACT_W-1:0]  act_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PORT_W-1:0] port_ff;
   logic              pend_v_ff;
   event_type         pend_ff;
   logic              out_v_ff;
   event_type         out_ff;
   logic              out_last_ff;

   // ---------------------------------------------------------------- control
   logic              accept, mem_rd_en, key_we, age_we, step_done;
   logic              rec_hit, rec_free, valid_set, valid_clr;
   logic              cnt_inc, cnt_dec, pend_load, pend_clr, out_load, out_last;
   logic [IW-1:0]     wr_idx, vidx;
   logic [AGE_W-1:0]  wr_age;
   event_type         pend_data;
   logic [CW-1:0]     cnt_next;
   logic [CW+2:0]     cnt_ext;
   logic              slot_v, last_idx, out_free, stall;
   slot_type          rd_slot;
   alu_op_type        alu_op;
   alu_res_type       alu_res;

   assign slot_v   = valid_ff[idx_ff];
   assign last_idx = (idx_ff == IW'(MAX_PEERS - 1));
   assign out_free = !out_v_ff || rsp.ready;
   // a second drop during a tick must wait until the held one can move out
   assign stall    = pend_v_ff && !out_free;
   assign alu_op   = (act_ff == ACT_TICK) ? OP_AGE : OP_KEY;
   assign cnt_next = count_ff + CW'(cnt_inc) - CW'(cnt_dec);
   assign cnt_ext  = (CW + 3)'(cnt_next);

   pkt_slot_mem #(
      .DEPTH (MAX_PEERS),
      .IW    (IW)
   ) u_mem (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .rd_idx     (idx_ff),
      .rd_data    (rd_slot),
      .key_we     (key_we),
      .age_we     (age_we),
      .wr_idx     (wr_idx),
      .wr_address (addr_ff),
      .wr_port    (port_ff),
      .wr_age     (wr_age)
   );

   pkt_alu u_alu (
      .op    (alu_op),
      .key_a (rd_slot.address),
      .key_b (addr_ff),
      .age   (rd_slot.age),
      .limit (age_limit_ff),
      .step  (age_step_ff),
      .res   (alu_res)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.action)
                  ACT_ALIVE, ACT_DISCONNECT, ACT_TICK: state_in = ST_READ;
                  default:                             state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (step_done) begin
               if (!last_idx)             state_in = ST_READ;
               else if (act_ff == ACT_TICK) state_in = ST_FLUSH;
               else                       state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_FLUSH;
         ST_FLUSH: begin
            if (!pend_v_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      accept    = 1'b0;
      mem_rd_en = 1'b0;
      key_we    = 1'b0;
      age_we    = 1'b0;
      step_done = 1'b0;
      rec_hit   = 1'b0;
      rec_free  = 1'b0;
      valid_set = 1'b0;
      valid_clr = 1'b0;
      cnt_inc   = 1'b0;
      cnt_dec   = 1'b0;
      pend_load = 1'b0;
      pend_clr  = 1'b0;
      out_load  = 1'b0;
      out_last  = 1'b0;
      wr_idx    = idx_ff;
      vidx      = idx_ff;
      wr_age    = '0;
      pend_data = '{kind: EV_DEAD, address: rd_slot.address, port: rd_slot.port,
                    count: cnt_ext[CNT_W-1:0]};
      case (state_ff)
         ST_IDLE: accept = req.valid;
         ST_READ: mem_rd_en = 1'b1;
         ST_EVAL: begin
            case (act_ff)
               ACT_ALIVE, ACT_DISCONNECT: begin
                  // first match and first free slot, in slot order
                  rec_hit   = slot_v && alu_res.flag && !hit_ff;
                  rec_free  = !slot_v && !free_ff;
                  step_done = 1'b1;
               end
               ACT_TICK: begin
                  if (slot_v && !alu_res.flag) begin
                     age_we    = 1'b1;
                     wr_age    = alu_res.age_next;
                     step_done = 1'b1;
                  end else if (slot_v) begin
                     if (!stall) begin
                        valid_clr = 1'b1;
                        cnt_dec   = 1'b1;
                        pend_load = 1'b1;
                        // a held notice now knows it is not the last one
                        out_load  = pend_v_ff;
                        step_done = 1'b1;
                     end
                  end else begin
                     step_done = 1'b1;
                  end
               end
               default: step_done = 1'b1;
            endcase
         end
         ST_COMMIT: begin
            pend_load = 1'b1;
            if (act_ff == ACT_ALIVE) begin
               if (hit_ff) begin
                  age_we = 1'b1;
                  wr_idx = hit_idx_ff;
               end else if (free_ff) begin
                  key_we    = 1'b1;
                  age_we    = 1'b1;
                  wr_idx    = free_idx_ff;
                  vidx      = free_idx_ff;
                  valid_set = 1'b1;
                  cnt_inc   = 1'b1;
               end
            end else if (hit_ff) begin
               vidx      = hit_idx_ff;
               valid_clr = 1'b1;
               cnt_dec   = 1'b1;
            end
            pend_data = '{kind: (act_ff == ACT_ALIVE) ? EV_ALIVE : EV_DEAD,
                          address: addr_ff, port: port_ff,
                          count: cnt_ext[CNT_W-1:0]};
         end
         ST_FLUSH: begin
            if (pend_v_ff && out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               pend_clr = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         age_limit_ff <= AGE_LIMIT_RST;
         age_step_ff  <= AGE_STEP_RST;
         valid_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         act_ff       <= ACT_ALIVE;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_AGE_LIMIT: age_limit_ff <= csr_data;
               CSR_AGE_STEP:  age_step_ff  <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            act_ff  <= req.action;
            idx_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (step_done) begin
            idx_ff <= IW'(idx_ff + 1'b1);
         end
         if (rec_hit)   hit_ff        <= 1'b1;
         if (rec_free)  free_ff       <= 1'b1;
         if (valid_set) valid_ff[vidx] <= 1'b1;
         if (valid_clr) valid_ff[vidx] <= 1'b0;
         count_ff <= cnt_next;
         if (pend_load)     pend_v_ff <= 1'b1;
         else if (pend_clr) pend_v_ff <= 1'b0;
         if (out_load)       out_v_ff <= 1'b1;
         else if (rsp.ready) out_v_ff <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req.peer_address;
         port_ff <= req.peer_port;
      end
      if (rec_hit)   hit_idx_ff  <= idx_ff;
      if (rec_free)  free_idx_ff <= idx_ff;
      if (pend_load) pend_ff     <= pend_data;
      if (out_load) begin
         out_ff      <= pend_ff;
         out_last_ff <= out_last;
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = out_v_ff;
   assign rsp.event_kind    = out_ff.kind;
   assign rsp.event_address = out_ff.address;
   assign rsp.event_port    = out_ff.port;
   assign rsp.peer_count    = out_ff.count;
   assign rsp.last          = out_last_ff;

   // ---------------------------------------------------------------- checks
   a_count_matches_valid : assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(valid_ff))
      else $error("peer count out of step with slot valid bits");

   a_idle_no_pending : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff)
      else $error("held result left over at idle");

   a_non_last_only_tick : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_last_ff |-> act_ff == ACT_TICK)
      else $error("non-final result outside a tick");

   a_stall_holds_scan : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && !step_done |=> state_ff == ST_EVAL && $stable(idx_ff))
      else $error("slot scan moved during a stall");

endmodule

FILE: tb/sv/peer_keepalive_table_unit_tb.sv
module peer_keepalive_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pkt_pkg::*;

   localparam int MAX_PEERS = 4;

   // action code 3 has no meaning: the block must swallow it without a result
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   // a tick scan that drops nothing ends without a result; wait past it with margin
   localparam int SETTLE_CYCLES = 2 * MAX_PEERS + 12;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
   } peer_request_type;

   typedef struct {
      event_type ev;
      logic      last;
   } peer_event_type;

   logic clock;
   logic reset;
   logic             csr_we;
   logic             csr_index;
   logic [CFG_W-1:0] csr_data;

   pkt_req_if req_ch ();
   pkt_rsp_if rsp_ch ();

   peer_keepalive_table_unit #(
      .MAX_PEERS (MAX_PEERS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the peer table and its two config registers
   // ---------------------------------------------------------------------
   logic              slot_used [MAX_PEERS];
   logic [ADDR_W-1:0] slot_addr [MAX_PEERS];
   logic [PORT_W-1:0] slot_port [MAX_PEERS];
   logic [AGE_W-1:0]  slot_age  [MAX_PEERS];
   logic [CFG_W-1:0]  cfg_limit;
   logic [CFG_W-1:0]  cfg_step;

   peer_request_type pending_requests [$];   // fed by the stimulus, drained by the driver
   peer_event_type   expected_events  [$];   // what the block owes us, oldest first

   int  error_count;
   int  cycle_count;
   bit  idle_on;          // random bubbles on both sides; cleared for the tail of the run
   int  hold_requests;    // bumped by the stimulus to ask for one long rsp stall
   int  hold_served;
   int  hold_left;
   int  stall_left;
   int  send_gap;
   logic [ADDR_W-1:0] addr_pool [6];

   function automatic logic [CNT_W-1:0] held_peers();
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_PEERS; i++)
         if (slot_used[i])
            n++;
      return n;
   endfunction

   function automatic int find_slot(logic [ADDR_W-1:0] addr);
      int hit;
      hit = -1;
      for (int i = 0; i < MAX_PEERS; i++)
         if (hit < 0 && slot_used[i] && slot_addr[i] == addr)
            hit = i;
      return hit;
   endfunction

   function automatic peer_event_type make_event(logic kind, logic [ADDR_W-1:0] addr,
                                                 logic [PORT_W-1:0] port);
      peer_event_type e;
      e.ev.kind    = kind;
      e.ev.address = addr;
      e.ev.port    = port;
      e.ev.count   = held_peers();   // count is taken after the table change
      e.last       = 1'b0;
      return e;
   endfunction

   // Apply one accepted request to the shadow table and queue the events it causes.
   function automatic void table_update(peer_request_type r);
      peer_event_type evs [$];
      int             hit;
      bit             placed;
      logic [8:0]     aged;
      hit    = -1;
      placed = 1'b0;
      case (r.action)
         ACT_ALIVE: begin
            hit = find_slot(r.address);
            if (hit >= 0) begin
               // known peer: refresh age only, stored port stays
               slot_age[hit] = '0;
            end else begin
               // new peer goes to the lowest free slot; a full table does not store it, the response still goes out
               for (int i = 0; i < MAX_PEERS; i++) begin
                  if (!placed && !slot_used[i]) begin
                     slot_used[i] = 1'b1;
                     slot_addr[i] = r.address;
                     slot_port[i] = r.port;
                     slot_age[i]  = '0;
                     placed       = 1'b1;
                  end
               end
            end
            evs.push_back(make_event(EV_ALIVE, r.address, r.port));
         end
         ACT_DISCONNECT: begin
            hit = find_slot(r.address);
            if (hit >= 0)
               slot_used[hit] = 1'b0;
            // notice goes out even for an unknown peer, with the request's fields
            evs.push_back(make_event(EV_DEAD, r.address, r.port));
         end
         ACT_TICK: begin
            // slot order scan; request address/port are don't-care here
            for (int i = 0; i < MAX_PEERS; i++) begin
               if (slot_used[i]) begin
                  if (slot_age[i] <= {1'b0, cfg_limit}) begin
                     aged = {1'b0, slot_age[i]} + {2'b00, cfg_step};
                     slot_age[i] = (aged > {1'b0, AGE_MAX}) ? AGE_MAX : aged[AGE_W-1:0];
                  end else begin
                     slot_used[i] = 1'b0;
                     evs.push_back(make_event(EV_DEAD, slot_addr[i], slot_port[i]));
                  end
               end
            end
         end
         default: ;   // unused code: nothing happens
      endcase
      if (evs.size() > 0)
         evs[evs.size() - 1].last = 1'b1;
      foreach (evs[k])
         expected_events.push_back(evs[k]);
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
         error_count++;
      end
   endfunction

   function automatic void queue_request(logic [ACT_W-1:0] action, logic [ADDR_W-1:0] addr,
                                         logic [PORT_W-1:0] port);
      peer_request_type r;
      r.action  = action;
      r.address = addr;
      r.port    = port;
      pending_requests.push_back(r);
   endfunction

   // Mostly well-formed traffic on a small address pool so that hits, refreshes,
   // full-table drops and aging removals all keep happening; a slice of fresh
   // random addresses and the unused code as noise.
   function automatic void queue_random_requests(int n);
      int               pick;
      logic [ADDR_W-1:0] addr;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         addr = ($urandom_range(0, 4) == 0) ? $urandom() : addr_pool[$urandom_range(0, 5)];
         if (pick < 45)
            queue_request(ACT_ALIVE, addr, PORT_W'($urandom_range(0, 65535)));
         else if (pick < 65)
            queue_request(ACT_DISCONNECT, addr, PORT_W'($urandom_range(0, 65535)));
         else if (pick < 94)
            queue_request(ACT_TICK, $urandom(), PORT_W'($urandom_range(0, 65535)));
         else
            queue_request(ACT_UNUSED, $urandom(), PORT_W'($urandom_range(0, 65535)));
      end
   endfunction

   // Config writes only happen with the block idle, so the shadow copy is
   // updated right at the write.
   task automatic write_reg(logic index, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      if (index == CSR_AGE_LIMIT)
         cfg_limit = value;
      else
         cfg_step = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for every request to go in and every owed event to come out, then
   // give a tick with no removals time to finish its scan.
   task automatic drain_and_settle();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request driver: pops the pending queue, random bubbles between requests
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      peer_request_type r;
      peer_request_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            r.action  = req_ch.action;
            r.address = req_ch.peer_address;
            r.port    = req_ch.peer_port;
            table_update(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               nxt = pending_requests.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.action       <= nxt.action;
               req_ch.peer_address <= nxt.address;
               req_ch.peer_port    <= nxt.port;
               if (idle_on && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 5);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response ready: long hold on request, short random stalls otherwise
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_ready
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served  = hold_requests;
         hold_left    = LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left   = $urandom_range(1, 5) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: every accepted event against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      peer_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t ns: unexpected event: kind %0d addr 0x%0h port 0x%0h", $time,
                     rsp_ch.event_kind, rsp_ch.event_address, rsp_ch.event_port);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", want.ev.kind, rsp_ch.event_kind);
            check_field("event_address", want.ev.address, rsp_ch.event_address);
            check_field("event_port", want.ev.port, rsp_ch.event_port);
            check_field("peer_count", want.ev.count, rsp_ch.peer_count);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL peer_keepalive_table_unit");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      // known values on every input before the first edge
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_AGE_LIMIT;
      csr_data            = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_ALIVE;
      req_ch.peer_address = '0;
      req_ch.peer_port    = '0;
      rsp_ch.ready        = 1'b0;
      error_count         = 0;
      cycle_count         = 0;
      idle_on             = 1'b1;
      hold_requests       = 0;
      hold_served         = 0;
      hold_left           = 0;
      stall_left          = 0;
      send_gap            = 0;
      cfg_limit           = AGE_LIMIT_RST;
      cfg_step            = AGE_STEP_RST;
      for (int i = 0; i < MAX_PEERS; i++)
         slot_used[i] = 1'b0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < 6; i++)
         addr_pool[i] = $urandom();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset settings (limit 10, step 5).
      // Fill the table, with address and port extremes.
      @(negedge clock);
      queue_request(ACT_ALIVE, 32'h0000_0000, 16'h0000);
      queue_request(ACT_ALIVE, 32'hFFFF_FFFF, 16'hFFFF);
      queue_request(ACT_ALIVE, 32'h0A00_0001, 16'h0001);
      queue_request(ACT_ALIVE, 32'hC0A8_0102, 16'h0002);
      // full table: response still goes out, peer not stored
      queue_request(ACT_ALIVE, 32'h5555_AAAA, 16'h0003);
      // known peer with a new port: response echoes it, table keeps the old one
      queue_request(ACT_ALIVE, 32'h0000_0000, 16'h1234);
      // disconnect of an absent peer, then of a present one
      queue_request(ACT_DISCONNECT, 32'h5555_AAAA, 16'hAAAA);
      queue_request(ACT_DISCONNECT, 32'h0A00_0001, 16'h5555);
      // freed middle slot is reused
      queue_request(ACT_ALIVE, 32'h5555_AAAA, 16'h0003);
      queue_request(ACT_UNUSED, 32'hDEAD_BEEF, 16'hBEEF);
      // age all four to 10, refresh one, then age out the rest in slot order
      queue_request(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF);
      queue_request(ACT_TICK, 32'h0000_0000, 16'h0000);
      queue_request(ACT_ALIVE, 32'hFFFF_FFFF, 16'h7FFF);
      queue_request(ACT_TICK, 32'h1234_5678, 16'h8000);
      queue_request(ACT_TICK, 32'h8765_4321, 16'h0001);
      queue_request(ACT_TICK, 32'h0000_0000, 16'h0000);
      queue_request(ACT_TICK, 32'h0000_0000, 16'h0000);
      // tick on an empty table: nothing comes back
      queue_request(ACT_TICK, 32'hA5A5_A5A5, 16'h5A5A);
      queue_request(ACT_ALIVE, 32'h8000_0001, 16'h8001);
      queue_request(ACT_DISCONNECT, 32'h8000_0001, 16'h7FFE);
      queue_request(ACT_DISCONNECT, 32'hFFFF_FFFF, 16'hFFFF);
      drain_and_settle();

      // Low extremes: anything older than zero dies on the next tick.
      write_reg(CSR_AGE_LIMIT, 7'd0);
      write_reg(CSR_AGE_STEP, 7'd1);
      @(negedge clock);
      queue_random_requests(30);
      drain_and_settle();

      // High extremes.
      write_reg(CSR_AGE_LIMIT, 7'd127);
      write_reg(CSR_AGE_STEP, 7'd127);
      @(negedge clock);
      queue_random_requests(30);
      drain_and_settle();

      // Back-pressure: the response side holds off long enough that the
      // output register fills and request ready drops while requests wait.
      write_reg(CSR_AGE_LIMIT, CFG_W'($urandom_range(0, 127)));
      write_reg(CSR_AGE_STEP, CFG_W'($urandom_range(1, 127)));
      @(negedge clock);
      hold_requests = hold_requests + 1;
      for (int i = 0; i < MAX_PEERS; i++)
         queue_request(ACT_ALIVE, $urandom(), PORT_W'($urandom_range(0, 65535)));
      queue_random_requests(20);
      drain_and_settle();

      write_reg(CSR_AGE_LIMIT, CFG_W'($urandom_range(0, 15)));
      write_reg(CSR_AGE_STEP, CFG_W'($urandom_range(1, 8)));
      @(negedge clock);
      queue_random_requests(40);
      drain_and_settle();

      // Tail of the run at full rate on both sides.
      write_reg(CSR_AGE_LIMIT, CFG_W'($urandom_range(0, 127)));
      write_reg(CSR_AGE_STEP, CFG_W'($urandom_range(1, 127)));
      @(negedge clock);
      idle_on = 1'b0;
      queue_random_requests(30);
      drain_and_settle();

      if (error_count == 0 && expected_events.size() == 0) begin
         $display("PASS peer_keepalive_table_unit");
      end else begin
         $display("FAIL peer_keepalive_table_unit");
      end
      $finish;
   end

endmodule
